// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                capture;
    logic                push;
    logic                pop;
    logic                load;
    logic [STATUS_W-1:0] code;
  } spq_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic empty;
  } spq_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ctrl.sv =====
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire spq_sts_t sts,
  output spq_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.code       = ST_DONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.load = 1'b1;
        if (sts.kind == KIND_PUSH) begin
          if (sts.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.push = 1'b1;
          end
        end else begin
          if (sts.empty) begin
            cmd.code = ST_EMPTY;
          end else begin
            cmd.pop = 1'b1;
          end
        end
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spq_datapath.sv =====
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
)
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire spq_cmd_t                 cmd,
  output spq_sts_t                      sts,
  input  wire logic                     kind,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic signed [DATA_W-1:0] key,
  output logic [STATUS_W-1:0]           status,
  output logic signed [DATA_W-1:0]      head_value,
  output logic signed [DATA_W-1:0]      head_key,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [OCC_W-1:0]              occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic                     kind_q;
  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] key_q;

  logic signed [DATA_W-1:0] val_mem [DEPTH];
  logic signed [DATA_W-1:0] key_mem [DEPTH];
  logic signed [DATA_W-1:0] val_nxt [DEPTH];
  logic signed [DATA_W-1:0] key_nxt [DEPTH];
  logic [DEPTH-1:0]         stays;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign sts.kind  = kind_q;
  assign sts.full  = (count == FULL_COUNT);
  assign sts.empty = (count == '0);

  // an entry keeps its slot when it outranks the incoming key
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic prev_stays;
    logic signed [DATA_W-1:0] val_up;
    logic signed [DATA_W-1:0] key_up;

    assign stays[i] = (IDX < count) && (key_q < key_mem[i]);

    if (i == 0) begin : g_first
      assign prev_stays = 1'b0;
    end else begin : g_rest
      assign prev_stays = stays[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign val_up = val_mem[i];
      assign key_up = key_mem[i];
    end else begin : g_inner
      assign val_up = val_mem[i+1];
      assign key_up = key_mem[i+1];
    end

    always_comb begin
      val_nxt[i] = val_mem[i];
      key_nxt[i] = key_mem[i];
      if (cmd.push) begin
        if (stays[i]) begin
          val_nxt[i] = val_mem[i];
          key_nxt[i] = key_mem[i];
        end else if (i == 0 || prev_stays) begin
          val_nxt[i] = value_q;
          key_nxt[i] = key_q;
        end else begin
          val_nxt[i] = val_mem[i-1 < 0 ? 0 : i-1];
          key_nxt[i] = key_mem[i-1 < 0 ? 0 : i-1];
        end
      end else if (cmd.pop) begin
        val_nxt[i] = val_up;
        key_nxt[i] = key_up;
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      value_q <= value;
      key_q   <= key;
    end
    if (cmd.push || cmd.pop) begin
      val_mem <= val_nxt;
      key_mem <= key_nxt;
    end
    if (cmd.load) begin
      status     <= cmd.code;
      head_value <= (count_next != '0) ? val_nxt[0] : '0;
      head_key   <= (count_next != '0) ? key_nxt[0] : '0;
      is_empty   <= (count_next == '0);
      is_full    <= (count_next == FULL_COUNT);
      occupancy  <= OCC_W'(count_next);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH (value, signed key) entries, largest key at the
// head, newest first among equal keys. Each transaction is a push (kind 0) or a pop
// (kind 1) and returns one result with the status and the head, flags and count after
// the step. A transaction runs through a capture step that registers the item, then an
// execute step in which every entry register compares its key with the new key in
// parallel and shifts or holds. The next item is taken only once the execute step is done
// and the result register is free or is being taken in the same cycle.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = SPQ_DEPTH
)
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     kind,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic signed [DATA_W-1:0] key,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STATUS_W-1:0]           status,
  output logic signed [DATA_W-1:0]      head_value,
  output logic signed [DATA_W-1:0]      head_key,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [OCC_W-1:0]              occupancy
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .value      (value),
    .key        (key),
    .status     (status),
    .head_value (head_value),
    .head_key   (head_key),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .occupancy  (occupancy)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [STATUS_W-1:0]      status,
  input wire logic signed [DATA_W-1:0] head_value,
  input wire logic signed [DATA_W-1:0] head_key,
  input wire logic                     is_empty,
  input wire logic                     is_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_empty && is_full))
    else $error("empty and full together");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> (head_value == '0) && (head_key == '0))
    else $error("empty queue shows a head");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> is_empty)
    else $error("ignored pop on non-empty queue");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> is_full)
    else $error("rejected push on non-full queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .head_value (head_value),
  .head_key   (head_key),
  .is_empty   (is_empty),
  .is_full    (is_full)
);

`default_nettype wire

// ===== tb/sv/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int NUM_ITEMS   = 1000;
  localparam int CALM_AFTER  = 850;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   head_value;
    logic signed [DATA_W-1:0]   head_key;
    logic                       is_empty;
    logic                       is_full;
    logic [OCC_W-1:0]           occupancy;
  } head_report_t;

  class spq_checker;
    logic signed [DATA_W-1:0] held_values[SPQ_DEPTH];
    logic signed [DATA_W-1:0] held_keys[SPQ_DEPTH];
    int held_count;
    head_report_t pending_heads[$];
    int mismatches, checked, pushes, pops, rejects, empty_pops;

    function new();
      held_count = 0;
      mismatches = 0;
      checked    = 0;
      pushes     = 0;
      pops       = 0;
      rejects    = 0;
      empty_pops = 0;
    endfunction

    function void note_request(logic k, logic signed [DATA_W-1:0] v,
                               logic signed [DATA_W-1:0] kk);
      head_report_t r;
      int pos;
      r = '0;
      r.status = ST_DONE;
      if (k == KIND_PUSH) begin
        if (held_count >= SPQ_DEPTH) begin
          r.status = ST_FULL;
          rejects++;
        end else begin
          pos = 0;
          while (pos < held_count && kk < held_keys[pos]) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_values[i] = held_values[i-1];
            held_keys[i]   = held_keys[i-1];
          end
          held_values[pos] = v;
          held_keys[pos]   = kk;
          held_count++;
          pushes++;
        end
      end else begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          for (int i = 1; i < held_count; i++) begin
            held_values[i-1] = held_values[i];
            held_keys[i-1]   = held_keys[i];
          end
          held_count--;
          pops++;
        end
      end
      r.head_value = (held_count != 0) ? held_values[0] : '0;
      r.head_key   = (held_count != 0) ? held_keys[0] : '0;
      r.is_empty   = (held_count == 0);
      r.is_full    = (held_count == SPQ_DEPTH);
      r.occupancy  = OCC_W'(held_count);
      pending_heads.push_back(r);
    endfunction

    function void check_response(head_report_t got);
      head_report_t exp;
      checked++;
      if (pending_heads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d value=%0d key=%0d empty=%0b full=%0b occ=%0d",
                   $time, got.status, got.head_value, got.head_key, got.is_empty,
                   got.is_full, got.occupancy);
        return;
      end
      exp = pending_heads.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch on result %0d", $time, checked);
          $display("  exp status=%0d value=%0d key=%0d empty=%0b full=%0b occ=%0d",
                   exp.status, exp.head_value, exp.head_key, exp.is_empty, exp.is_full,
                   exp.occupancy);
          $display("  got status=%0d value=%0d key=%0d empty=%0b full=%0b occ=%0d",
                   got.status, got.head_value, got.head_key, got.is_empty, got.is_full,
                   got.occupancy);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_PUSH;
  logic signed [DATA_W-1:0] value = '0;
  logic signed [DATA_W-1:0] key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic signed [DATA_W-1:0] head_value;
  logic signed [DATA_W-1:0] head_key;
  logic is_empty;
  logic is_full;
  logic [OCC_W-1:0] occupancy;

  spq_checker sb = new();
  logic calm = 1'b0;
  int idle_pct = 25;
  int stall_left = 0;
  int sent = 0;

  sorted_priority_queue #(.DEPTH(SPQ_DEPTH)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .head_value (head_value),
    .head_key   (head_key),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .occupancy  (occupancy)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(kind, value, key);
      if (out_valid && !out_stall)
        sb.check_response({status, head_value, head_key, is_empty, is_full, occupancy});
    end
  end

  // receiver backpressure in bursts
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic k, input logic signed [DATA_W-1:0] v,
                           input logic signed [DATA_W-1:0] kk);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    key      <= kk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return DATA_W'(int'($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] dkeys[16];
    logic signed [DATA_W-1:0] dvals[16];
    int push_pct, seg_len;
    dkeys = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 5, 5, 5, 0,
              32'sh7FFF_FFFF, -1, 32'sh8000_0000, 100, -100, 1, 2, 3};
    dvals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 2, 3, 32'sh5555_5555,
              32'shAAAA_AAAA, 7, 9, 10, 11, 12, 13, 14};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pop on empty, fill with extremes and ties, push on full, partial drain
    send_item(KIND_POP, $urandom, $urandom);
    for (int i = 0; i < 16; i++) send_item(KIND_PUSH, dvals[i], dkeys[i]);
    send_item(KIND_PUSH, 32'sh1234_5678, 32'sh7FFF_FFFF);
    repeat (4) send_item(KIND_POP, $urandom, $urandom);

    while (sent < NUM_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       push_pct = 90;
        1:       push_pct = 10;
        2:       push_pct = 70;
        3:       push_pct = 30;
        default: push_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) begin
        if (sent >= CALM_AFTER) calm = 1'b1;
        if ($urandom_range(0, 99) < push_pct)
          send_item(KIND_PUSH, $urandom, pick_key());
        else
          send_item(KIND_POP, $urandom, $urandom);
      end
    end
    in_valid <= 1'b0;
    calm = 1'b1;

    while (sb.pending_heads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d transactions: %0d pushes, %0d pops, %0d pushes on full, %0d pops on empty",
             sent, sb.pushes, sb.pops, sb.rejects, sb.empty_pops);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_heads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", sb.pending_heads.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
tb/sv/tb_sorted_priority_queue.sv
